/* rtl/noisy_gaussian_kernel_eval_assert.svh */
// Assertion macros shared by the RTL.
`ifndef NOISY_GAUSSIAN_KERNEL_EVAL_ASSERT_SVH
`define NOISY_GAUSSIAN_KERNEL_EVAL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NGK_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NGK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ngk_pkg.sv */
`default_nettype none

package ngk_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned LEN_W     = 48;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd1;

    localparam logic [LEN_W-1:0] LEN_RESET = 48'd65536;

    localparam logic [32:0] PROD_ONE = 33'h0_8000_0000;
    localparam logic [32:0] PROD_MAX = 33'h0_FFFF_FFFF;
    localparam logic [32:0] PROD_MIN = 33'h1_0000_0000;

    localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
    localparam logic [23:0] LN2_Q24     = 24'd11629080;
    localparam logic [29:0] X_CAP       = 30'h2000_0000;
    localparam logic [30:0] EXP_ONE     = 31'h4000_0000;
    localparam logic [3:0]  TAYLOR_LAST = 4'd12;
    localparam logic [7:0]  SHIFT_LIMIT = 8'd40;

    localparam int unsigned MUL_STEPS  = 8;
    localparam int unsigned DIV_STEPS  = 71;
    localparam int unsigned GDIV_STEPS = 32;

    typedef struct packed {
        logic [63:0] dsq;
        logic [63:0] s;
        logic [79:0] num;
        logic        f_neg;
        logic        last;
    } ngk_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ngk_q_status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_PUSH
    } ngk_front_state_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_DIV,
        B_EXPX,
        B_EXPN,
        B_EXPR,
        B_EXPC,
        B_TAY_MUL,
        B_TAY_RCP,
        B_TAY_ACC,
        B_EXPE,
        B_NORM,
        B_SQRT,
        B_GCHK,
        B_GDIV,
        B_TERM,
        B_PROD,
        B_UPD,
        B_EMIT
    } ngk_back_state_t;

    // floor(2^32 / k) for the Taylor divisors; the quotient it gives is low by at most one.
    function automatic logic [32:0] recip_q32(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'h0_8000_0000;
            4'd3:    r = 33'h0_5555_5555;
            4'd4:    r = 33'h0_4000_0000;
            4'd5:    r = 33'h0_3333_3333;
            4'd6:    r = 33'h0_2AAA_AAAA;
            4'd7:    r = 33'h0_2492_4924;
            4'd8:    r = 33'h0_2000_0000;
            4'd9:    r = 33'h0_1C71_C71C;
            4'd10:   r = 33'h0_1999_9999;
            4'd11:   r = 33'h0_1745_D174;
            4'd12:   r = 33'h0_1555_5555;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/ngk_if.sv */
`default_nettype none

interface ngk_item_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coord_a;
    logic        [31:0] var_a;
    logic signed [31:0] coord_b;
    logic        [31:0] var_b;
    logic signed [31:0] scale_factor;
    logic               last_dim;

    modport source (
        output valid, coord_a, var_a, coord_b, var_b, scale_factor, last_dim,
        input  ready
    );
    modport sink (
        input  valid, coord_a, var_a, coord_b, var_b, scale_factor, last_dim,
        output ready
    );
endinterface

interface ngk_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] kernel_value;
    logic        error_flag;

    modport source (output valid, kernel_value, error_flag, input ready);
    modport sink (input valid, kernel_value, error_flag, output ready);
endinterface

interface ngk_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ngk_pkg::CFG_IDX_W-1:0] index;
    logic [ngk_pkg::LEN_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/ngk_front.sv */
`default_nettype none

module ngk_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ngk_item_if.sink                        item,
    input  wire logic [ngk_pkg::LEN_W-1:0]  length_sq,
    input  wire logic [ngk_pkg::LEN_W-1:0]  length,
    input  wire ngk_pkg::ngk_q_status_t     q_status,
    output logic                            push,
    output ngk_pkg::ngk_job_t               push_data
);
    import ngk_pkg::*;

    ngk_front_state_t state_reg, state_next;
    logic [2:0]   step_reg;
    logic [31:0]  ad_reg, af_reg;
    logic [32:0]  vsum_reg;
    logic         f_neg_reg, last_reg;
    logic [63:0]  dsq_reg;
    logic [62:0]  fsq_reg;
    logic [110:0] lf_acc_reg;
    logic [79:0]  num_reg;
    logic [63:0]  s_reg;

    logic         take;
    logic [32:0]  diff, abs_diff;
    logic [31:0]  abs_f;
    logic [31:0]  op_a, op_b;
    logic [63:0]  mul_p;
    logic [63:0]  lf;
    logic [64:0]  s_sum;

    assign take = item.valid && item.ready;

    assign diff     = {item.coord_a[31], item.coord_a} - {item.coord_b[31], item.coord_b};
    assign abs_diff = diff[32] ? (33'd0 - diff) : diff;
    assign abs_f    = item.scale_factor[31] ? (32'd0 - item.scale_factor) : item.scale_factor;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (take) state_next = F_MUL;
            F_MUL:   if (step_reg == 3'(MUL_STEPS - 1)) state_next = F_SUM;
            F_SUM:   state_next = F_PUSH;
            F_PUSH:  if (!q_status.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        item.ready = (state_reg == F_IDLE);
        push       = (state_reg == F_PUSH) && !q_status.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
                step_reg <= '0;
            else if (state_reg == F_MUL)
                step_reg <= step_reg + 3'd1;
        end
    end

    // One shared multiplier walks through the squares and the partial products.
    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                op_a = ad_reg;
                op_b = ad_reg;
            end
            3'd1:
            begin
                op_a = af_reg;
                op_b = af_reg;
            end
            3'd2:
            begin
                op_a = length_sq[31:0];
                op_b = fsq_reg[31:0];
            end
            3'd3:
            begin
                op_a = length_sq[31:0];
                op_b = {1'b0, fsq_reg[62:32]};
            end
            3'd4:
            begin
                op_a = {16'd0, length_sq[47:32]};
                op_b = fsq_reg[31:0];
            end
            3'd5:
            begin
                op_a = {16'd0, length_sq[47:32]};
                op_b = {1'b0, fsq_reg[62:32]};
            end
            3'd6:
            begin
                op_a = length[31:0];
                op_b = af_reg;
            end
            3'd7:
            begin
                op_a = {16'd0, length[47:32]};
                op_b = af_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_p = op_a * op_b;

    assign lf    = (lf_acc_reg[110:96] != '0) ? '1 : lf_acc_reg[95:32];
    assign s_sum = {32'd0, vsum_reg} + {1'b0, lf};

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ad_reg    <= abs_diff[31:0];
            af_reg    <= abs_f;
            vsum_reg  <= {1'b0, item.var_a} + {1'b0, item.var_b};
            f_neg_reg <= item.scale_factor[31];
            last_reg  <= item.last_dim;
        end
        if (state_reg == F_MUL)
        begin
            case (step_reg)
                3'd0:    dsq_reg    <= mul_p;
                3'd1:    fsq_reg    <= mul_p[62:0];
                3'd2:    lf_acc_reg <= {47'd0, mul_p};
                3'd3:    lf_acc_reg <= lf_acc_reg + {15'd0, mul_p, 32'd0};
                3'd4:    lf_acc_reg <= lf_acc_reg + {15'd0, mul_p, 32'd0};
                3'd5:    lf_acc_reg <= lf_acc_reg + {mul_p[46:0], 64'd0};
                3'd6:    num_reg    <= {16'd0, mul_p};
                3'd7:    num_reg    <= num_reg + {mul_p[47:0], 32'd0};
                default: num_reg    <= num_reg;
            endcase
        end
        if (state_reg == F_SUM)
            s_reg <= s_sum[64] ? '1 : s_sum[63:0];
    end

    assign push_data = '{dsq: dsq_reg, s: s_reg, num: num_reg,
                         f_neg: f_neg_reg, last: last_reg};

endmodule

`default_nettype wire

/* rtl/ngk_queue.sv */
`default_nettype none

module ngk_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire ngk_pkg::ngk_job_t      push_data,
    input  wire logic                   pop,
    output ngk_pkg::ngk_job_t           pop_data,
    output ngk_pkg::ngk_q_status_t      status
);
    import ngk_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ngk_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* rtl/ngk_back.sv */
`default_nettype none

module ngk_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ngk_pkg::ngk_job_t      pop_data,
    input  wire ngk_pkg::ngk_q_status_t q_status,
    output logic                        pop,
    ngk_result_if.source                result
);
    import ngk_pkg::*;

    ngk_back_state_t state_reg, state_next;
    logic [6:0]   cnt_reg;
    logic [32:0]  rp_reg;
    logic         err_reg;
    logic         out_valid_reg;
    logic [31:0]  out_value_reg;
    logic         out_err_reg;

    ngk_job_t     job_reg;
    logic [63:0]  rem_reg;
    logic [70:0]  dq_reg;
    logic [29:0]  x_reg;
    logic [7:0]   n_reg;
    logic [32:0]  r_reg;
    logic [23:0]  rr_reg;
    logic [30:0]  term_reg;
    logic [32:0]  sum_reg;
    logic [30:0]  p_reg;
    logic [30:0]  qe_reg;
    logic [31:0]  core_reg;
    logic [63:0]  sn_reg;
    logic [117:0] gnum_reg;
    logic [63:0]  res_reg;
    logic [63:0]  sq_bit_reg;
    logic [31:0]  g_reg;
    logic [31:0]  tmag_reg;
    logic [33:0]  prod_reg;

    logic         s_zero, out_free, out_load;
    logic [64:0]  div_t, div_r;
    logic         div_ge;
    logic [60:0]  ln_p;
    logic [30:0]  nl_p;
    logic [32:0]  r1, r2;
    logic [7:0]   n1, n2;
    logic [54:0]  tay_p;
    logic [63:0]  rcp_p;
    logic [3:0]   tay_k;
    logic [34:0]  qk_p;
    logic [30:0]  tay_chk, tay_term;
    logic [30:0]  sum_clamp;
    logic [31:0]  sum_dbl, core_w;
    logic [64:0]  sq_rb;
    logic         sq_ge;
    logic [31:0]  rt;
    logic         g_sat;
    logic [32:0]  gd_t, gd_r;
    logic         gd_ge;
    logic [63:0]  tm_p;
    logic [32:0]  pmag;
    logic [64:0]  pp;
    logic         prod_neg;
    logic [32:0]  rp_new;

    assign s_zero   = (job_reg.s == '0);
    assign out_free = !out_valid_reg || result.ready;
    assign tay_k    = cnt_reg[3:0];
    assign rt       = res_reg[31:0];

    // Restoring division of dsq * 2^7 by s; the dividend shifts out as the quotient shifts in.
    assign div_t  = {rem_reg, dq_reg[70]};
    assign div_ge = (div_t >= {1'b0, job_reg.s});
    assign div_r  = div_ge ? (div_t - {1'b0, job_reg.s}) : div_t;

    assign ln_p = x_reg * LOG2E_Q30;
    assign nl_p = n_reg[6:0] * LN2_Q24;

    // Bring the remainder into [0, ln2) and move the exponent with it.
    always_comb
    begin
        r1 = r_reg[32] ? (r_reg + {9'd0, LN2_Q24}) : r_reg;
        n1 = r_reg[32] ? (n_reg - 8'd1) : n_reg;
        if (!r1[32] && (r1 >= {9'd0, LN2_Q24}))
        begin
            r2 = r1 - {9'd0, LN2_Q24};
            n2 = n1 + 8'd1;
        end
        else
        begin
            r2 = r1;
            n2 = n1;
        end
    end

    assign tay_p    = term_reg * rr_reg;
    assign rcp_p    = p_reg * recip_q32(tay_k);
    assign qk_p     = qe_reg * tay_k;
    assign tay_chk  = p_reg - qk_p[30:0];
    assign tay_term = (tay_chk >= {27'd0, tay_k}) ? (qe_reg + 31'd1) : qe_reg;

    always_comb
    begin
        if (sum_reg[32])
            sum_clamp = '0;
        else if (sum_reg > {2'b0, EXP_ONE})
            sum_clamp = EXP_ONE;
        else
            sum_clamp = sum_reg[30:0];
        sum_dbl = {sum_clamp, 1'b0};
        if (n_reg[7])
            core_w = sum_dbl;
        else if (n_reg >= SHIFT_LIMIT)
            core_w = '0;
        else
            core_w = sum_dbl >> n_reg[5:0];
    end

    assign sq_rb = {1'b0, res_reg} + {1'b0, sq_bit_reg};
    assign sq_ge = ({1'b0, sn_reg} >= sq_rb);

    assign g_sat = (gnum_reg[117:64] != '0) || (gnum_reg[63:32] >= rt);
    assign gd_t  = {rem_reg[31:0], g_reg[31]};
    assign gd_ge = (gd_t >= {1'b0, rt});
    assign gd_r  = gd_ge ? (gd_t - {1'b0, rt}) : gd_t;

    assign tm_p = g_reg * core_reg;
    assign pmag = rp_reg[32] ? (33'd0 - rp_reg) : rp_reg;
    assign pp   = pmag * tmag_reg;

    assign prod_neg = rp_reg[32] ^ job_reg.f_neg;

    always_comb
    begin
        if (prod_reg == '0)
            rp_new = '0;
        else if (prod_neg)
            rp_new = (prod_reg >= {2'b01, 32'd0}) ? PROD_MIN
                                                  : (33'd0 - {1'b0, prod_reg[31:0]});
        else
            rp_new = (prod_reg > {1'b0, PROD_MAX}) ? PROD_MAX : prod_reg[32:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
                if (!q_status.empty)
                    state_next = (pop_data.s == '0) ? B_UPD : B_DIV;
            B_DIV:     if (cnt_reg == 7'(DIV_STEPS - 1)) state_next = B_EXPX;
            B_EXPX:    state_next = B_EXPN;
            B_EXPN:    state_next = B_EXPR;
            B_EXPR:    state_next = B_EXPC;
            B_EXPC:    state_next = B_TAY_MUL;
            B_TAY_MUL: state_next = B_TAY_RCP;
            B_TAY_RCP: state_next = B_TAY_ACC;
            B_TAY_ACC: state_next = (tay_k == TAYLOR_LAST) ? B_EXPE : B_TAY_MUL;
            B_EXPE:    state_next = B_NORM;
            B_NORM:    if (sn_reg[63:62] != 2'b00) state_next = B_SQRT;
            B_SQRT:    if (sq_bit_reg[0]) state_next = B_GCHK;
            B_GCHK:    state_next = g_sat ? B_TERM : B_GDIV;
            B_GDIV:    if (cnt_reg == 7'(GDIV_STEPS - 1)) state_next = B_TERM;
            B_TERM:    state_next = B_PROD;
            B_PROD:    state_next = B_UPD;
            B_UPD:     state_next = job_reg.last ? B_EMIT : B_IDLE;
            B_EMIT:    if (out_free) state_next = B_IDLE;
            default:   state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == B_IDLE) && !q_status.empty;
        out_load = (state_reg == B_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            rp_reg        <= PROD_ONE;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                B_IDLE:    cnt_reg <= '0;
                B_DIV:     cnt_reg <= cnt_reg + 7'd1;
                B_EXPC:    cnt_reg <= 7'd1;
                B_TAY_ACC: cnt_reg <= cnt_reg + 7'd1;
                B_GCHK:    cnt_reg <= '0;
                B_GDIV:    cnt_reg <= cnt_reg + 7'd1;
                default:   cnt_reg <= cnt_reg;
            endcase
            if (state_reg == B_UPD)
            begin
                if (s_zero)
                    err_reg <= 1'b1;
                else
                    rp_reg <= rp_new;
            end
            if (out_load)
            begin
                rp_reg  <= PROD_ONE;
                err_reg <= 1'b0;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg <= pop_data;
                rem_reg <= '0;
                dq_reg  <= {pop_data.dsq, 7'd0};
            end
            B_DIV:
            begin
                rem_reg <= div_r[63:0];
                dq_reg  <= {dq_reg[69:0], div_ge};
            end
            B_EXPX:
                x_reg <= (dq_reg > {41'd0, X_CAP}) ? X_CAP : dq_reg[29:0];
            B_EXPN:
                n_reg <= {1'b0, ln_p[60:54]};
            B_EXPR:
                r_reg <= {3'd0, x_reg} - {2'd0, nl_p};
            B_EXPC:
            begin
                rr_reg   <= r2[23:0];
                n_reg    <= n2;
                term_reg <= EXP_ONE;
                sum_reg  <= {2'b00, EXP_ONE};
            end
            B_TAY_MUL:
                p_reg <= tay_p[54:24];
            B_TAY_RCP:
                qe_reg <= rcp_p[62:32];
            B_TAY_ACC:
            begin
                term_reg <= tay_term;
                sum_reg  <= tay_k[0] ? (sum_reg - {2'b00, tay_term})
                                     : (sum_reg + {2'b00, tay_term});
            end
            B_EXPE:
            begin
                core_reg <= core_w;
                sn_reg   <= job_reg.s;
                gnum_reg <= {31'd0, job_reg.num, 7'd0};
            end
            B_NORM:
            begin
                // Normalise s by pairs of bits; the numerator moves one bit per pair,
                // since the square root moves by half the shift.
                if (sn_reg[63:62] == 2'b00)
                begin
                    sn_reg   <= {sn_reg[61:0], 2'b00};
                    gnum_reg <= {gnum_reg[116:0], 1'b0};
                end
                else
                begin
                    res_reg    <= '0;
                    sq_bit_reg <= {2'b01, 62'd0};
                end
            end
            B_SQRT:
            begin
                sn_reg     <= sq_ge ? (sn_reg - sq_rb[63:0]) : sn_reg;
                res_reg    <= sq_ge ? ((res_reg >> 1) + sq_bit_reg) : (res_reg >> 1);
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            B_GCHK:
            begin
                if (g_sat)
                    g_reg <= '1;
                else
                begin
                    rem_reg <= {32'd0, gnum_reg[63:32]};
                    g_reg   <= gnum_reg[31:0];
                end
            end
            B_GDIV:
            begin
                rem_reg <= {32'd0, gd_r[31:0]};
                g_reg   <= {g_reg[30:0], gd_ge};
            end
            B_TERM:
                tmag_reg <= tm_p[62:31];
            B_PROD:
                prod_reg <= pp[64:31];
            default:
                prod_reg <= prod_reg;
        endcase
        if (out_load)
        begin
            if (err_reg || rp_reg[32])
            begin
                out_value_reg <= '0;
                out_err_reg   <= 1'b1;
            end
            else
            begin
                out_value_reg <= (rp_reg > PROD_ONE) ? PROD_ONE[31:0] : rp_reg[31:0];
                out_err_reg   <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kernel_value = out_value_reg;
    assign result.error_flag   = out_err_reg;

endmodule

`default_nettype wire

/* rtl/noisy_gaussian_kernel_eval.sv */
// Noisy squared-exponential kernel, one dimension per input word.
// The item channel carries both coordinates, both noise variances, the scale
// factor and a last-dimension mark; the result channel carries one word per
// point pair, on its last dimension: the Q1.31 product and an error flag.
// The configuration channel writes length_sq (index 0) and length (index 1);
// other indices are ignored. It is always ready and should only be used while
// the block is idle.
// The front end takes a word, then works through the squares and the scaled
// length products before it hands the word to a small queue; it takes no
// new word until it has pushed the last. The back end works on one word at
// a time with bit-serial units: a 71-step divider for the exponent argument,
// 12 Taylor steps (multiply, reciprocal, accumulate), up to 32 normalising
// steps, a 32-step square root and a 32-step divider. A word with a zero
// denominator goes straight from idle to the update, which sets the error state.
// A finished result waits in an output register while the receiver stalls;
// the back end then holds before its next emission and the queue and front
// end fill up behind it.
// Reset restores both lengths to 1.0, the running product to 1.0 and clears
// the error state.
`default_nettype none
`include "noisy_gaussian_kernel_eval_assert.svh"

module noisy_gaussian_kernel_eval #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ngk_item_if.sink       item,
    ngk_result_if.source   result,
    ngk_cfg_if.sink        cfg
);
    import ngk_pkg::*;

    logic [LEN_W-1:0] length_sq_reg;
    logic [LEN_W-1:0] length_reg;

    logic          q_push, q_pop;
    ngk_job_t      q_push_data, q_pop_data;
    ngk_q_status_t q_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_sq_reg <= LEN_RESET;
            length_reg    <= LEN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_LENGTH_SQ: length_sq_reg <= cfg.data;
                REG_LENGTH:    length_reg    <= cfg.data;
                default:       length_reg    <= length_reg;
            endcase
        end
    end

    ngk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .length_sq (length_sq_reg),
        .length    (length_reg),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (q_push_data)
    );

    ngk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    ngk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (q_pop_data),
        .q_status (q_status),
        .pop      (q_pop),
        .result   (result)
    );

    `NGK_ASSERT_SAME(a_push_not_full, q_push, !q_status.full, "push into a full queue")
    `NGK_ASSERT_SAME(a_pop_not_empty, q_pop, !q_status.empty, "pop from an empty queue")
    `NGK_ASSERT_SAME(a_err_value_zero, result.valid && result.error_flag, result.kernel_value == 32'd0, "error result with a non-zero value")
    `NGK_ASSERT_NEXT(a_front_busy, item.valid && item.ready, !item.ready, "front end took a word while busy")

endmodule

`default_nettype wire
